@@ hdl/lpg_pkg.sv @@
`default_nettype none

package lpg_pkg;

	// Width of every coordinate field on the channels
	localparam int FIELD_W = 6;

	// Default number of coordinate bits the generator actually uses
	localparam int COORD_BITS_DEFAULT = 6;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture a new segment and set up the error term
		logic step;   // advance to the next raster point
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last;   // current point is the final one of the segment
	} status_t;

endpackage

`default_nettype wire

@@ hdl/lpg_seg_if.sv @@
`default_nettype none

interface lpg_seg_if;
	logic                        valid;
	logic                        ready;
	logic [lpg_pkg::FIELD_W-1:0] start_x;
	logic [lpg_pkg::FIELD_W-1:0] start_y;
	logic [lpg_pkg::FIELD_W-1:0] end_x;
	logic [lpg_pkg::FIELD_W-1:0] end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

`default_nettype wire

@@ hdl/lpg_pt_if.sv @@
`default_nettype none

interface lpg_pt_if;
	logic                        valid;
	logic                        ready;
	logic [lpg_pkg::FIELD_W-1:0] point_x;
	logic [lpg_pkg::FIELD_W-1:0] point_y;
	logic                        last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

`default_nettype wire

@@ hdl/lpg_ctrl.sv @@
`default_nettype none

module lpg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	output      logic             out_valid,
	input  wire logic             out_ready,
	input  wire lpg_pkg::status_t status,
	output      lpg_pkg::cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RUN);

	assign cmd.load = in_valid && in_ready;
	assign cmd.step = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// drop back to idle once the final point is taken
					if (cmd.step && status.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/lpg_datapath.sv @@
`default_nettype none

module lpg_datapath #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lpg_pkg::cmd_t               cmd,
	input  wire logic [lpg_pkg::FIELD_W-1:0] start_x,
	input  wire logic [lpg_pkg::FIELD_W-1:0] start_y,
	input  wire logic [lpg_pkg::FIELD_W-1:0] end_x,
	input  wire logic [lpg_pkg::FIELD_W-1:0] end_y,
	output      logic [lpg_pkg::FIELD_W-1:0] point_x,
	output      logic [lpg_pkg::FIELD_W-1:0] point_y,
	output      lpg_pkg::status_t            status
);

	localparam int N  = COORD_BITS;
	localparam int EW = COORD_BITS + 3;   // signed error term width

	logic [N-1:0]          cur_x_q, cur_y_q;
	logic [N-1:0]          step_x_q, step_y_q;
	logic [N-1:0]          remain_q;
	logic                  x_dom_q;
	logic signed [EW-1:0]  err_q;
	logic [N:0]            inc_s_q;
	logic signed [EW-1:0]  inc_d_q;

	// segment setup
	logic [N-1:0]          sx, sy, ex, ey;
	logic [N:0]            dx, dy;
	logic [N-1:0]          adx, ady, major, minor;
	logic                  x_dom;
	logic signed [EW-1:0]  err_init, inc_d_init;

	always_comb begin
		sx = start_x[N-1:0];
		sy = start_y[N-1:0];
		ex = end_x[N-1:0];
		ey = end_y[N-1:0];
		dx = {1'b0, ex} - {1'b0, sx};
		dy = {1'b0, ey} - {1'b0, sy};
		adx = dx[N] ? N'(-dx) : dx[N-1:0];
		ady = dy[N] ? N'(-dy) : dy[N-1:0];
		x_dom = (adx > ady);
		major = x_dom ? adx : ady;
		minor = x_dom ? ady : adx;
		err_init   = EW'({minor, 1'b0}) - EW'(major);
		inc_d_init = EW'({minor, 1'b0}) - EW'({major, 1'b0});
	end

	// per-point update
	logic                  err_pos;
	logic [N-1:0]          next_x, next_y;

	always_comb begin
		err_pos = !err_q[EW-1];
		next_x = cur_x_q;
		next_y = cur_y_q;
		if (x_dom_q) begin
			next_x = cur_x_q + step_x_q;
			if (err_pos) begin
				next_y = cur_y_q + step_y_q;
			end
		end else begin
			next_y = cur_y_q + step_y_q;
			if (err_pos) begin
				next_x = cur_x_q + step_x_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
		end else if (cmd.load) begin
			// a zero-length segment still yields its start point
			remain_q <= (major == '0) ? N'(1) : major;
		end else if (cmd.step) begin
			remain_q <= remain_q - N'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q  <= sx;
			cur_y_q  <= sy;
			step_x_q <= dx[N] ? '1 : ((|dx) ? N'(1) : '0);
			step_y_q <= dy[N] ? '1 : ((|dy) ? N'(1) : '0);
			x_dom_q  <= x_dom;
			err_q    <= err_init;
			inc_s_q  <= {minor, 1'b0};
			inc_d_q  <= inc_d_init;
		end else if (cmd.step) begin
			cur_x_q <= next_x;
			cur_y_q <= next_y;
			err_q   <= err_pos ? (err_q + inc_d_q) : (err_q + EW'(inc_s_q));
		end
	end

	assign point_x     = lpg_pkg::FIELD_W'(cur_x_q);
	assign point_y     = lpg_pkg::FIELD_W'(cur_y_q);
	assign status.last = (remain_q == N'(1));

endmodule

`default_nettype wire

@@ hdl/line_point_generator_core.sv @@
// Bresenham line point generator.
//
// Channel seg (sink) takes one line segment per transfer: start_x, start_y,
// end_x, end_y. Channel pt (source) gives the raster points of that segment
// in order, one per transfer, with last_point set on the final one. The
// start point is included and the end point is not; a zero-length segment
// gives just its start point, marked last. Ties between |dx| and |dy| step
// along y.
//
// Timing: a segment is taken only while the generator is idle. The first
// point is offered in the cycle after the segment transfer, then one point
// per cycle while pt.ready is high; a segment gives L points (L = max of
// |dx|, |dy|, at least 1). The rate is set by the single error-term
// update loop in the datapath, which advances once per point. When the
// receiver stalls, the current point is held in the position registers
// and the loop waits. Reset makes the block idle with seg.ready high and
// pt.valid low.
`default_nettype none

module line_point_generator_core #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lpg_seg_if.sink   seg,
	lpg_pt_if.source  pt
);

	lpg_pkg::cmd_t    cmd;
	lpg_pkg::status_t status;

	// Controller: idle/run sequencing and handshakes
	lpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.out_valid (pt.valid),
		.out_ready (pt.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: position, error term and point counter
	lpg_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.start_x (seg.start_x),
		.start_y (seg.start_y),
		.end_x   (seg.end_x),
		.end_y   (seg.end_y),
		.point_x (pt.point_x),
		.point_y (pt.point_y),
		.status  (status)
	);

	assign pt.last_point = status.last;

	// Never offer a point while taking a new segment
	a_idle_excl: assert property (@(posedge clk) disable iff (!arst_n)
		seg.ready |-> !pt.valid)
		else $error("segment ready while a point is pending");

	// A segment transfer starts point output in the next cycle
	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		(seg.valid && seg.ready) |=> pt.valid)
		else $error("no point after segment transfer");

	// Transfer of the final point returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && pt.ready && pt.last_point) |=> (seg.ready && !pt.valid))
		else $error("not idle after final point");

	// Any other point transfer keeps the segment running
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && pt.ready && !pt.last_point) |=> (pt.valid && !seg.ready))
		else $error("segment ended before its final point");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	typedef logic [lpg_pkg::FIELD_W-1:0] coord_t;

	// One segment as it goes over the seg channel
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} segment_t;

	// One raster point as it comes back over the pt channel
	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   last_point;
	} point_t;

	localparam int     RANDOM_SEGS  = 410;
	localparam int     CALM_TAIL    = 40;   // segments at the end sent with no idling
	localparam int     HOLD_AFTER   = 40;   // segments accepted before the long stall
	localparam int     HOLD_CYCLES  = 400;
	localparam int     SETTLE       = 20;
	localparam int     REPORT_MAX   = 10;
	localparam coord_t COORD_MAX    = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Driven values live here so that every input is known from time zero
	logic     seg_valid = 1'b0;
	segment_t seg_word  = '0;
	logic     pt_ready  = 1'b0;
	logic     hold_off  = 1'b0;

	segment_t segs_queued[$];
	point_t   points_due[$];

	int segs_sent      = 0;
	int total_segs     = 0;
	int points_checked = 0;
	int fault_count    = 0;
	int zero_len_segs  = 0;
	int x_major_segs   = 0;
	int y_major_segs   = 0;
	int tie_segs       = 0;

	int seg_gap = 0;
	int pt_gap  = 0;
	int seg_odds = 3;
	int pt_odds  = 3;
	int unsigned cycle_no = 0;

	logic calm;

	lpg_seg_if seg_ch ();
	lpg_pt_if  pt_ch ();

	assign seg_ch.valid   = seg_valid;
	assign seg_ch.start_x = seg_word.start_x;
	assign seg_ch.start_y = seg_word.start_y;
	assign seg_ch.end_x   = seg_word.end_x;
	assign seg_ch.end_y   = seg_word.end_y;
	assign pt_ch.ready    = pt_ready;

	// Drop all idling for the last few segments so the tail runs at full rate
	assign calm = (segs_sent + CALM_TAIL >= total_segs);

	line_point_generator_core #(
		.COORD_BITS(lpg_pkg::COORD_BITS_DEFAULT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg(seg_ch),
		.pt(pt_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Walk one segment with the integer error term and queue every raster
	// point it should produce. The start point is emitted, the end point is
	// not, and the final emitted point carries the last flag.
	function automatic void plot_segment(input segment_t s);
		coord_t            x, y;
		logic signed [6:0] dx, dy;
		logic        [6:0] adx, ady;
		logic        [7:0] twice_x, twice_y, inc_run;
		logic signed [8:0] err, inc_diag;
		logic signed [1:0] sx, sy;
		logic              x_major;
		int                steps;
		x   = s.start_x;
		y   = s.start_y;
		dx  = $signed({1'b0, s.end_x}) - $signed({1'b0, s.start_x});
		dy  = $signed({1'b0, s.end_y}) - $signed({1'b0, s.start_y});
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		twice_x = {adx, 1'b0};
		twice_y = {ady, 1'b0};
		sx = (dx > 0) ? 2'sd1 : ((dx < 0) ? -2'sd1 : 2'sd0);
		sy = (dy > 0) ? 2'sd1 : ((dy < 0) ? -2'sd1 : 2'sd0);
		// strict compare: a tie steps along y
		x_major = (twice_x > twice_y);

		if (adx == 0 && ady == 0) begin
			zero_len_segs++;
			points_due.push_back('{x, y, 1'b1});
			return;
		end

		if (twice_x == twice_y)
			tie_segs++;
		if (x_major) begin
			x_major_segs++;
			err      = $signed({1'b0, twice_y}) - $signed({2'b00, adx});
			inc_run  = twice_y;
			inc_diag = $signed({1'b0, twice_y}) - $signed({1'b0, twice_x});
			steps    = adx;
		end else begin
			y_major_segs++;
			err      = $signed({1'b0, twice_x}) - $signed({2'b00, ady});
			inc_run  = twice_x;
			inc_diag = $signed({1'b0, twice_x}) - $signed({1'b0, twice_y});
			steps    = ady;
		end

		for (int i = 0; i < steps; i++) begin
			points_due.push_back('{x, y, (i == steps - 1)});
			if (x_major) begin
				if (err >= 0) begin
					y   = y + {{(lpg_pkg::FIELD_W-2){sy[1]}}, sy};
					err = err + inc_diag;
				end else begin
					err = err + $signed({1'b0, inc_run});
				end
				x = x + {{(lpg_pkg::FIELD_W-2){sx[1]}}, sx};
			end else begin
				if (err >= 0) begin
					x   = x + {{(lpg_pkg::FIELD_W-2){sx[1]}}, sx};
					err = err + inc_diag;
				end else begin
					err = err + $signed({1'b0, inc_run});
				end
				y = y + {{(lpg_pkg::FIELD_W-2){sy[1]}}, sy};
			end
		end
	endfunction

	function automatic void push_seg(input int sx, input int sy, input int ex, input int ey);
		segs_queued.push_back('{coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey)});
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	// Pick 0, 1, max-1 or max so the random part keeps hitting the borders
	function automatic coord_t edge_coord();
		return $urandom_range(0, 1) ? COORD_MAX - coord_t'($urandom_range(0, 1))
			: coord_t'($urandom_range(0, 1));
	endfunction

	// Idle odds: 0 means no idling in this stretch, otherwise one chance in odds+1
	function automatic int pick_odds();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			2: return 5;
			default: return 12;
		endcase
	endfunction

	always @(posedge clk)
		cycle_no <= cycle_no + 1;

	// Segment driver: offer queued segments, hold each one until it transfers,
	// and insert random idle bursts between transfers.
	always @(posedge clk) begin
		if (!arst_n) begin
			seg_valid <= 1'b0;
			seg_gap   <= 0;
		end else begin
			// a transfer happened at this edge: predict its points now
			if (seg_valid && seg_ch.ready) begin
				plot_segment(seg_word);
				segs_sent <= segs_sent + 1;
			end

			// hold valid and payload while the offered segment waits for ready
			if (!seg_valid || seg_ch.ready) begin
				if (seg_gap != 0) begin
					seg_gap   <= seg_gap - 1;
					seg_valid <= 1'b0;
				end else if (segs_queued.size() == 0) begin
					seg_valid <= 1'b0;
				end else if (!calm && seg_odds != 0 && $urandom_range(0, seg_odds) == 0) begin
					seg_gap   <= $urandom_range(0, 10);
					seg_valid <= 1'b0;
				end else begin
					seg_valid <= 1'b1;
					seg_word  <= segs_queued.pop_front();
				end
			end

			if (cycle_no[7:0] == 8'd0)
				seg_odds <= pick_odds();
		end
	end

	// Point monitor: check every point transfer against the oldest expected
	// point, and drive ready with its own idle bursts plus the long stall.
	always @(posedge clk) begin : watch_points
		point_t got, want;
		if (!arst_n) begin
			pt_ready <= 1'b0;
			pt_gap   <= 0;
		end else begin
			if (pt_ch.valid && pt_ready) begin
				got = '{pt_ch.point_x, pt_ch.point_y, pt_ch.last_point};
				if (points_due.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("%0t: unexpected point x=%0d y=%0d last=%0b", $realtime,
							got.point_x, got.point_y, got.last_point);
				end else begin
					want = points_due.pop_front();
					points_checked++;
					if (got.point_x !== want.point_x || got.point_y !== want.point_y
						|| got.last_point !== want.last_point) begin
						fault_count++;
						if (fault_count <= REPORT_MAX)
							$display("%0t: expected x=%0d y=%0d last=%0b, got %0d %0d %0b",
								$realtime, want.point_x, want.point_y, want.last_point,
								got.point_x, got.point_y, got.last_point);
					end
				end
			end

			if (hold_off) begin
				pt_ready <= 1'b0;
			end else if (pt_gap != 0) begin
				pt_gap   <= pt_gap - 1;
				pt_ready <= 1'b0;
			end else if (!calm && pt_odds != 0 && $urandom_range(0, pt_odds) == 0) begin
				pt_gap   <= $urandom_range(0, 10);
				pt_ready <= 1'b0;
			end else begin
				pt_ready <= 1'b1;
			end

			if (cycle_no[7:0] == 8'd128)
				pt_odds <= pick_odds();
		end
	end

	// Long receiver stall: once traffic is flowing, hold ready low for a fixed
	// stretch while the driver keeps offering, so the block backs up and stops
	// taking segments.
	initial begin
		while (segs_sent < HOLD_AFTER)
			@(negedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b0;
	end

	// Run limit: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin : run_segments
		segment_t s;
		int pick;
		// Directed: zero length at both corners, full-range diagonals, axes,
		// near-axis lines, ties, single steps, and one segment in each of five octants.
		push_seg(0, 0, 0, 0);
		push_seg(63, 63, 63, 63);
		push_seg(0, 0, 63, 63);
		push_seg(63, 63, 0, 0);
		push_seg(63, 0, 0, 63);
		push_seg(0, 63, 63, 0);
		push_seg(0, 0, 63, 0);
		push_seg(63, 0, 0, 0);
		push_seg(0, 0, 0, 63);
		push_seg(0, 63, 0, 0);
		push_seg(0, 0, 63, 1);
		push_seg(63, 63, 0, 62);
		push_seg(0, 0, 1, 63);
		push_seg(63, 63, 62, 0);
		push_seg(5, 5, 7, 7);
		push_seg(20, 30, 21, 30);
		push_seg(20, 30, 20, 29);
		push_seg(10, 10, 13, 12);
		push_seg(10, 10, 7, 12);
		push_seg(10, 10, 13, 8);
		push_seg(10, 10, 12, 13);
		push_seg(10, 10, 8, 7);
		push_seg(42, 21, 21, 42);
		push_seg(33, 12, 33, 12);

		// Random: mostly full-range segments, some short ones around a random
		// start (zero length included), some with coordinates on the borders.
		for (int n = 0; n < RANDOM_SEGS; n++) begin
			pick = $urandom_range(0, 19);
			s.start_x = coord_t'($urandom_range(0, COORD_MAX));
			s.start_y = coord_t'($urandom_range(0, COORD_MAX));
			if (pick < 11) begin
				s.end_x = coord_t'($urandom_range(0, COORD_MAX));
				s.end_y = coord_t'($urandom_range(0, COORD_MAX));
			end else if (pick < 16) begin
				s.end_x = coord_t'(clamp_coord(int'(s.start_x) + $urandom_range(0, 16) - 8));
				s.end_y = coord_t'(clamp_coord(int'(s.start_y) + $urandom_range(0, 16) - 8));
			end else begin
				s.start_x = edge_coord();
				s.start_y = edge_coord();
				s.end_x   = edge_coord();
				s.end_y   = edge_coord();
			end
			segs_queued.push_back(s);
		end
		total_segs = segs_queued.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every segment to transfer and every point to come back,
		// then give the block time to show any stray output.
		while (segs_sent != total_segs || points_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d segments: %0d zero-length, %0d x-major, %0d y-major (%0d ties)",
			total_segs, zero_len_segs, x_major_segs, y_major_segs, tie_segs);
		$display("checked %0d raster points, %0d faults", points_checked, fault_count);
		if (fault_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ files.f @@
hdl/lpg_pkg.sv
hdl/lpg_seg_if.sv
hdl/lpg_pt_if.sv
hdl/lpg_ctrl.sv
hdl/lpg_datapath.sv
hdl/line_point_generator_core.sv
bench/testbench.sv
